### rtl/smbw_pkg.sv
`timescale 1ns / 1ps
package smbw_pkg;

  // offset and byte widths
  localparam int OFF_W  = 24;
  localparam int BYTE_W = 8;

  // configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_TARGET_TYPE  = 2'd0;
  localparam logic [1:0] REG_TARGET_INDEX = 2'd1;
  localparam logic [1:0] REG_TABLE_LIMIT  = 2'd2;

  localparam logic [OFF_W-1:0] TABLE_LIMIT_RST = OFF_W'(65535);

  // status codes
  localparam logic [1:0] ST_END     = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;

  // framing constants
  localparam logic [BYTE_W-1:0] END_TYPE    = 8'd127;
  localparam logic [BYTE_W-1:0] MIN_HDR_LEN = 8'd4;

  // result queue
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] table_byte;
    logic              first_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [OFF_W-1:0] found_offset;
    logic [OFF_W-1:0] total_size;
  } out_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] target_type;
    logic [BYTE_W-1:0] target_index;
    logic [OFF_W-1:0]  table_limit;
  } cfg_t;

endpackage

### rtl/smbw_cfg.sv
`timescale 1ns / 1ps
module smbw_cfg
  import smbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_TARGET_TYPE:  cfg_nxt.target_type  = pwdata[BYTE_W-1:0];
        REG_TARGET_INDEX: cfg_nxt.target_index = pwdata[BYTE_W-1:0];
        REG_TABLE_LIMIT:  cfg_nxt.table_limit  = pwdata[OFF_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_type  <= '0;
      cfg_r.target_index <= '0;
      cfg_r.table_limit  <= TABLE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read mux
  always_comb begin
    case (reg_idx)
      REG_TARGET_TYPE:  prdata = CFG_DW'(cfg_r.target_type);
      REG_TARGET_INDEX: prdata = CFG_DW'(cfg_r.target_index);
      REG_TABLE_LIMIT:  prdata = CFG_DW'(cfg_r.table_limit);
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### rtl/smbw_front.sv
`timescale 1ns / 1ps
module smbw_front
  import smbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      byte_vld,
  input  in_word_t  byte_word,
  output logic      res_vld,
  output out_word_t res_word
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_LEN,
    PH_FMT,
    PH_STR
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [OFF_W-1:0]  start_r, start_nxt;
  logic [BYTE_W-1:0] flen_r, flen_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] ctype_r, ctype_nxt;
  logic              pz_r, pz_nxt;
  logic [BYTE_W-1:0] mcnt_r, mcnt_nxt;
  logic              hit_r, hit_nxt;
  logic [OFF_W-1:0]  hoff_r, hoff_nxt;

  phase_t            cur_phase;
  logic [OFF_W-1:0]  cur_off;
  logic              cur_hit;
  logic [BYTE_W-1:0] cur_mcnt;
  logic [BYTE_W-1:0] tb;
  logic [BYTE_W-1:0] pos_inc;
  logic [OFF_W-1:0]  off_inc;
  logic              done;
  logic [1:0]        st;
  logic [OFF_W-1:0]  size;

  assign tb       = byte_word.table_byte;
  assign pos_inc  = pos_r + BYTE_W'(1);

  // a first byte restarts the walk from a clean state
  assign cur_phase = byte_word.first_byte ? PH_TYPE : phase_r;
  assign cur_off   = byte_word.first_byte ? '0 : off_r;
  assign cur_hit   = byte_word.first_byte ? 1'b0 : hit_r;
  assign cur_mcnt  = byte_word.first_byte ? '0 : mcnt_r;
  assign off_inc   = cur_off + OFF_W'(1);

  // framing of one byte
  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    start_nxt = start_r;
    flen_nxt  = flen_r;
    pos_nxt   = pos_r;
    ctype_nxt = ctype_r;
    pz_nxt    = pz_r;
    mcnt_nxt  = mcnt_r;
    hit_nxt   = hit_r;
    hoff_nxt  = hoff_r;
    done      = 1'b0;
    st        = ST_LIMIT;
    size      = cur_off;
    if (byte_vld && byte_word.first_byte) begin
      off_nxt   = '0;
      start_nxt = '0;
      flen_nxt  = '0;
      pos_nxt   = '0;
      ctype_nxt = '0;
      pz_nxt    = 1'b0;
      mcnt_nxt  = '0;
      hit_nxt   = 1'b0;
      hoff_nxt  = '0;
      phase_nxt = PH_TYPE;
    end
    if (byte_vld && cur_phase != PH_IDLE) begin
      if (cur_off >= cfg.table_limit) begin
        // already at the limit: the byte is dropped
        done = 1'b1;
        st   = ST_LIMIT;
        size = cur_off;
      end else begin
        case (cur_phase)
          PH_TYPE: begin
            start_nxt = cur_off;
            ctype_nxt = tb;
            if (!cur_hit && tb == cfg.target_type) begin
              if (cur_mcnt == cfg.target_index) begin
                hit_nxt  = 1'b1;
                hoff_nxt = cur_off;
              end else begin
                mcnt_nxt = cur_mcnt + BYTE_W'(1);
              end
            end
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            flen_nxt = tb;
            if (tb < MIN_HDR_LEN) begin
              done = 1'b1;
              st   = ST_BAD_LEN;
              size = start_r;
            end else begin
              pos_nxt   = BYTE_W'(2);
              phase_nxt = PH_FMT;
            end
          end
          PH_FMT: begin
            pos_nxt = pos_inc;
            if (pos_inc >= flen_r) begin
              pz_nxt    = 1'b0;
              phase_nxt = PH_STR;
            end
          end
          PH_STR: begin
            if (tb == '0 && pz_r) begin
              if (ctype_r == END_TYPE) begin
                done = 1'b1;
                st   = ST_END;
                size = off_inc;
              end else begin
                pz_nxt    = 1'b0;
                phase_nxt = PH_TYPE;
              end
            end else begin
              pz_nxt = (tb == '0);
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
        if (!done) begin
          off_nxt = off_inc;
          if (off_inc >= cfg.table_limit) begin
            done = 1'b1;
            st   = ST_LIMIT;
            size = off_inc;
          end
        end
      end
      if (done) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      off_r   <= '0;
      start_r <= '0;
      flen_r  <= '0;
      pos_r   <= '0;
      ctype_r <= '0;
      pz_r    <= 1'b0;
      mcnt_r  <= '0;
      hit_r   <= 1'b0;
      hoff_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
      flen_r  <= flen_nxt;
      pos_r   <= pos_nxt;
      ctype_r <= ctype_nxt;
      pz_r    <= pz_nxt;
      mcnt_r  <= mcnt_nxt;
      hit_r   <= hit_nxt;
      hoff_r  <= hoff_nxt;
    end
  end

  // result of the ending byte
  assign res_vld               = done;
  assign res_word.status       = st;
  assign res_word.found        = hit_nxt;
  assign res_word.found_offset = hit_nxt ? hoff_nxt : '0;
  assign res_word.total_size   = size;

`ifndef SYNTH
  // an idle walker ignores bytes that do not start a walk
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE && !(byte_vld && byte_word.first_byte)) |-> !res_vld)
    else $error("result without an active walk");

  // every finished walk leaves the walker idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (phase_r == PH_IDLE))
    else $error("walker still active after a result");

  // a hit is kept until a new walk starts
  a_hit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && !(byte_vld && byte_word.first_byte)) |=> hit_r)
    else $error("hit lost within a walk");
`endif

endmodule

### rtl/smbw_fifo.sv
`timescale 1ns / 1ps
module smbw_fifo
  import smbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_word_t wr_word,
  output logic      full,
  input  logic      rd_en,
  output logic      empty,
  output out_word_t rd_word
);

  out_word_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_word = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

`ifndef SYNTH
  // the front never offers a word to a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en)
    else $error("word offered to a full result queue");

  // count stays within the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  // a write alone grows the count by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("result queue count did not track a write");
`endif

endmodule

### rtl/smbios_structure_walker.sv
`timescale 1ns / 1ps
// channel   ports                                 word accepted when
// input     push, full, in_word                   push && !full
// result    pop, empty, out_word                  pop && !empty
// config    psel, penable, pwrite, paddr, pwdata  psel && penable && pwrite && pready
//
// one table byte per cycle while full is low; the framing state machine handles each byte in its cycle
// a result enters the two-word result queue at the edge that takes the ending byte
// and is on out_word after that edge once no older result is waiting ahead of it
// full rises only when both queue words are waiting, so input stalls follow pop stalls
// rst_n is synchronous; registers reset to target 0, index 0, limit 65535
module smbios_structure_walker
  import smbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_word_t          in_word,
  output logic              empty,
  input  logic              pop,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      byte_vld;
  logic      res_vld;
  out_word_t res_word;

  assign byte_vld = push && !full;

  // configuration registers
  smbw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte framing and search
  smbw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_vld  (byte_vld),
    .byte_word (in_word),
    .res_vld   (res_vld),
    .res_word  (res_word)
  );

  // result queue
  smbw_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_vld),
    .wr_word (res_word),
    .full    (full),
    .rd_en   (pop),
    .empty   (empty),
    .rd_word (out_word)
  );

endmodule
